// File: rtl/rmq_pkg.sv
// shared types, constants and helpers for the matrix to quaternion block
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int IN_W = 16;
    localparam int DIFF_W = IN_W + 1;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        COMP_X,
        COMP_Y,
        COMP_Z,
        COMP_W
    } rmq_comp_t;

    typedef struct packed {
        logic      degen;
        rmq_comp_t pslot;
        rmq_comp_t slot_a;
        rmq_comp_t slot_b;
        rmq_comp_t slot_c;
    } rmq_ctl_t;

    localparam int CTL_W = $bits(rmq_ctl_t);

    function automatic rmq_comp_t rmq_succ(input rmq_comp_t c);
        rmq_comp_t r;
        case (c)
            COMP_X:  r = COMP_Y;
            COMP_Y:  r = COMP_Z;
            default: r = COMP_X;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/rotation_matrix_to_quaternion.sv
// top level of the rotation matrix to quaternion converter
`timescale 1ns / 1ps

// Converts one 3x3 rotation matrix in signed Q2.14 per item into a unit quaternion
// (x, y, z, w), accepting a new item every clock cycle while the output side keeps up.
// The front end picks the pivot and radicand in the accept cycle and drops the item into
// a four-entry queue; the back end is a fully pipelined square root (one root bit per
// stage) on a radicand of RW = max(FRAC_BITS, 17) + 2 bits, followed by three parallel
// pipelined dividers (one quotient bit per stage). A stall at the output freezes the
// back pipeline; the queue keeps taking items until it is full.

module rotation_matrix_to_quaternion import rmq_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [IN_W-1:0] m00,
    input  logic signed [IN_W-1:0] m01,
    input  logic signed [IN_W-1:0] m02,
    input  logic signed [IN_W-1:0] m10,
    input  logic signed [IN_W-1:0] m11,
    input  logic signed [IN_W-1:0] m12,
    input  logic signed [IN_W-1:0] m20,
    input  logic signed [IN_W-1:0] m21,
    input  logic signed [IN_W-1:0] m22,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [IN_W-1:0] quat_x,
    output logic signed [IN_W-1:0] quat_y,
    output logic signed [IN_W-1:0] quat_z,
    output logic signed [IN_W-1:0] quat_w,
    output logic                   degenerate
);

    localparam int RW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int NW = RW + FRAC_BITS - 2;
    localparam int PW = (NW + 1) / 2;
    localparam int DW = FRAC_BITS + 16;
    localparam int QW = CTL_W + RW + 3 * DIFF_W;

    rmq_ctl_t                 f_ctl;
    logic [RW-1:0]            f_rad;
    logic signed [DIFF_W-1:0] f_d_a, f_d_b, f_d_c;
    logic                     q_full;
    logic                     q_empty;
    logic                     q_pop;
    logic [QW-1:0]            q_rdata;

    rmq_front #(
        .FRAC_BITS(FRAC_BITS),
        .RW(RW)
    ) u_front (
        .m00(m00), .m01(m01), .m02(m02),
        .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22),
        .ctl(f_ctl),
        .rad(f_rad),
        .d_a(f_d_a),
        .d_b(f_d_b),
        .d_c(f_d_c)
    );

    assign in_stall = q_full;

    rmq_queue #(.W(QW)) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(in_valid && !q_full),
        .wdata({f_ctl, f_rad, f_d_a, f_d_b, f_d_c}),
        .pop(q_pop),
        .rdata(q_rdata),
        .full(q_full),
        .empty(q_empty)
    );

    rmq_back #(
        .FRAC_BITS(FRAC_BITS),
        .RW(RW),
        .NW(NW),
        .PW(PW),
        .DW(DW)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(!q_empty),
        .in_ctl(rmq_ctl_t'(q_rdata[QW-1 -: CTL_W])),
        .in_rad(q_rdata[3*DIFF_W +: RW]),
        .in_d_a($signed(q_rdata[2*DIFF_W +: DIFF_W])),
        .in_d_b($signed(q_rdata[DIFF_W +: DIFF_W])),
        .in_d_c($signed(q_rdata[DIFF_W-1:0])),
        .take(q_pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .quat_x(quat_x),
        .quat_y(quat_y),
        .quat_z(quat_z),
        .quat_w(quat_w),
        .degenerate(degenerate)
    );

endmodule

// File: rtl/rmq_front.sv
// front end: trace test, pivot choice, radicand and off-diagonal terms
`timescale 1ns / 1ps

module rmq_front import rmq_pkg::*; #(
    parameter int FRAC_BITS = 14,
    parameter int RW = 19
) (
    input  logic signed [IN_W-1:0]   m00,
    input  logic signed [IN_W-1:0]   m01,
    input  logic signed [IN_W-1:0]   m02,
    input  logic signed [IN_W-1:0]   m10,
    input  logic signed [IN_W-1:0]   m11,
    input  logic signed [IN_W-1:0]   m12,
    input  logic signed [IN_W-1:0]   m20,
    input  logic signed [IN_W-1:0]   m21,
    input  logic signed [IN_W-1:0]   m22,
    output rmq_ctl_t                 ctl,
    output logic [RW-1:0]            rad,
    output logic signed [DIFF_W-1:0] d_a,
    output logic signed [DIFF_W-1:0] d_b,
    output logic signed [DIFF_W-1:0] d_c
);

    localparam int SW = RW + 1;
    localparam logic signed [SW-1:0] ONE = SW'(1) <<< FRAC_BITS;

    logic signed [IN_W-1:0] mm [3][3];
    logic signed [IN_W-1:0] dg [3];
    logic signed [SW-1:0]   trace;
    logic signed [SW-1:0]   rad_s;
    rmq_comp_t              piv;
    rmq_comp_t              sj;
    rmq_comp_t              sk;

    always_comb
    begin
        mm[0][0] = m00; mm[0][1] = m01; mm[0][2] = m02;
        mm[1][0] = m10; mm[1][1] = m11; mm[1][2] = m12;
        mm[2][0] = m20; mm[2][1] = m21; mm[2][2] = m22;
        dg[0] = m00;
        dg[1] = m11;
        dg[2] = m22;
        trace = SW'(m00) + SW'(m11) + SW'(m22);
        piv = COMP_X;
        if (m11 > m00)
        begin
            piv = COMP_Y;
        end
        if (m22 > dg[piv])
        begin
            piv = COMP_Z;
        end
        sj = rmq_succ(piv);
        sk = rmq_succ(sj);
        ctl = '0;
        if (trace > 0)
        begin
            rad_s = trace + ONE;
            ctl.pslot = COMP_W;
            ctl.slot_a = COMP_X;
            ctl.slot_b = COMP_Y;
            ctl.slot_c = COMP_Z;
            d_a = DIFF_W'(m12) - DIFF_W'(m21);
            d_b = DIFF_W'(m20) - DIFF_W'(m02);
            d_c = DIFF_W'(m01) - DIFF_W'(m10);
        end
        else
        begin
            rad_s = SW'(dg[piv]) - SW'(dg[sj]) - SW'(dg[sk]) + ONE;
            ctl.pslot = piv;
            ctl.slot_a = COMP_W;
            ctl.slot_b = sj;
            ctl.slot_c = sk;
            d_a = DIFF_W'(mm[sj][sk]) - DIFF_W'(mm[sk][sj]);
            d_b = DIFF_W'(mm[piv][sj]) + DIFF_W'(mm[sj][piv]);
            d_c = DIFF_W'(mm[piv][sk]) + DIFF_W'(mm[sk][piv]);
        end
        ctl.degen = (rad_s <= 0);
        rad = ctl.degen ? RW'(1) : rad_s[RW-1:0];
    end

endmodule

// File: rtl/rmq_queue.sv
// short item queue between front and back
`timescale 1ns / 1ps

module rmq_queue import rmq_pkg::*; #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [W-1:0]  mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/rmq_sqrt.sv
// pipelined integer square root, one root bit per stage, with sideband
`timescale 1ns / 1ps

module rmq_sqrt #(
    parameter int NW = 31,
    parameter int PW = 16,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NW-1:0]     n,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [PW-1:0]     root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int NPW = 2 * PW;

    logic [PW-1:0]     rem_reg  [PW];
    logic [PW-1:0]     root_reg [PW];
    logic [NPW-1:0]    nsh_reg  [PW];
    logic [SIDE_W-1:0] side_reg [PW];
    logic              vld_reg  [PW];

    for (genvar s = 0; s < PW; s++)
    begin : g_stage
        logic [PW-1:0]     rem_in;
        logic [PW-1:0]     root_in;
        logic [NPW-1:0]    nsh_in;
        logic [SIDE_W-1:0] side_s;
        logic              vld_s;
        logic [PW+1:0]     trial_rem;
        logic [PW+1:0]     trial;
        logic              take;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign root_in = '0;
            assign nsh_in = NPW'(n);
            assign side_s = side_in;
            assign vld_s = in_valid;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign nsh_in = nsh_reg[s-1];
            assign side_s = side_reg[s-1];
            assign vld_s = vld_reg[s-1];
        end

        assign trial_rem = {rem_in, nsh_in[NPW-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign take = (trial_rem >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= take ? PW'(trial_rem - trial) : PW'(trial_rem);
                root_reg[s] <= {root_in[PW-2:0], take};
                nsh_reg[s] <= nsh_in << 2;
                side_reg[s] <= side_s;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_s;
            end
        end
    end

    assign out_valid = vld_reg[PW-1];
    assign root = root_reg[PW-1];
    assign side_out = side_reg[PW-1];

endmodule

// File: rtl/rmq_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module rmq_div #(
    parameter int DW = 30,
    parameter int PW = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] dividend,
    input  logic [PW-1:0] divisor,
    output logic [DW-1:0] quotient
);

    logic [PW-1:0] rem_reg [DW];
    logic [DW-1:0] quo_reg [DW];
    logic [DW-1:0] dsh_reg [DW];
    logic [PW-1:0] dvs_reg [DW];

    for (genvar s = 0; s < DW; s++)
    begin : g_stage
        logic [PW-1:0] rem_in;
        logic [DW-1:0] quo_in;
        logic [DW-1:0] dsh_in;
        logic [PW-1:0] dvs_in;
        logic [PW:0]   t;
        logic          take;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign dsh_in = dividend;
            assign dvs_in = divisor;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign dsh_in = dsh_reg[s-1];
            assign dvs_in = dvs_reg[s-1];
        end

        assign t = {rem_in, dsh_in[DW-1]};
        assign take = (t >= {1'b0, dvs_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= take ? PW'(t - {1'b0, dvs_in}) : PW'(t);
                quo_reg[s] <= {quo_in[DW-2:0], take};
                dsh_reg[s] <= dsh_in << 1;
                dvs_reg[s] <= dvs_in;
            end
        end
    end

    assign quotient = quo_reg[DW-1];

endmodule

// File: rtl/rmq_back.sv
// back end: pivot root, three scaled divisions, saturation and output register
`timescale 1ns / 1ps

module rmq_back import rmq_pkg::*; #(
    parameter int FRAC_BITS = 14,
    parameter int RW = 19,
    parameter int NW = 31,
    parameter int PW = 16,
    parameter int DW = 30
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  rmq_ctl_t                 in_ctl,
    input  logic [RW-1:0]            in_rad,
    input  logic signed [DIFF_W-1:0] in_d_a,
    input  logic signed [DIFF_W-1:0] in_d_b,
    input  logic signed [DIFF_W-1:0] in_d_c,
    output logic                     take,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [IN_W-1:0]   quat_x,
    output logic signed [IN_W-1:0]   quat_y,
    output logic signed [IN_W-1:0]   quat_z,
    output logic signed [IN_W-1:0]   quat_w,
    output logic                     degenerate
);

    localparam int SQ_SIDE_W = CTL_W + 3 * DIFF_W;
    localparam int DL_W = CTL_W + PW + 3;

    logic                     en;
    logic                     sq_valid;
    logic [PW-1:0]            sq_root;
    logic [SQ_SIDE_W-1:0]     sq_side;
    logic signed [DIFF_W-1:0] sd_a, sd_b, sd_c;
    logic [DIFF_W-1:0]        mag_a, mag_b, mag_c;
    logic [DW-1:0]            dvd_a_reg, dvd_b_reg, dvd_c_reg;
    logic [PW-1:0]            p_reg;
    logic [DL_W-1:0]          prep_side_reg;
    logic                     prep_vld_reg;
    logic [DW-1:0]            quo_a, quo_b, quo_c;
    logic [DL_W-1:0]          dl_reg [DW];
    logic                     dl_vld_reg [DW];
    rmq_ctl_t                 f_ctl;
    logic [PW-1:0]            f_p;
    logic                     f_neg_a, f_neg_b, f_neg_c;
    logic [IN_W-1:0]          res [4];
    logic                     out_valid_reg;
    logic [IN_W-1:0]          qx_reg, qy_reg, qz_reg, qw_reg;
    logic                     degen_reg;

    function automatic logic [IN_W-1:0] sat_mag(input logic [DW-1:0] q, input logic neg);
        logic [IN_W-1:0] r;
        if (neg)
        begin
            r = (q > DW'(32768)) ? 16'h8000 : IN_W'(-q[IN_W-1:0]);
        end
        else
        begin
            r = (q > DW'(32767)) ? 16'h7fff : q[IN_W-1:0];
        end
        return r;
    endfunction

    assign en = !out_valid_reg || !out_stall;
    assign take = en && in_valid;

    rmq_sqrt #(
        .NW(NW),
        .PW(PW),
        .SIDE_W(SQ_SIDE_W)
    ) u_sqrt (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(in_valid),
        .n(NW'(in_rad) << (FRAC_BITS - 2)),
        .side_in({in_ctl, in_d_a, in_d_b, in_d_c}),
        .out_valid(sq_valid),
        .root(sq_root),
        .side_out(sq_side)
    );

    always_comb
    begin
        sd_a = $signed(sq_side[3*DIFF_W-1 -: DIFF_W]);
        sd_b = $signed(sq_side[2*DIFF_W-1 -: DIFF_W]);
        sd_c = $signed(sq_side[DIFF_W-1:0]);
        mag_a = sd_a[DIFF_W-1] ? DIFF_W'(-sd_a) : DIFF_W'(sd_a);
        mag_b = sd_b[DIFF_W-1] ? DIFF_W'(-sd_b) : DIFF_W'(sd_b);
        mag_c = sd_c[DIFF_W-1] ? DIFF_W'(-sd_c) : DIFF_W'(sd_c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_a_reg <= (DW'(mag_a) << (FRAC_BITS - 2)) + DW'(sq_root >> 1);
            dvd_b_reg <= (DW'(mag_b) << (FRAC_BITS - 2)) + DW'(sq_root >> 1);
            dvd_c_reg <= (DW'(mag_c) << (FRAC_BITS - 2)) + DW'(sq_root >> 1);
            p_reg <= sq_root;
            prep_side_reg <= {sq_side[SQ_SIDE_W-1 -: CTL_W], sq_root,
                              sd_a[DIFF_W-1], sd_b[DIFF_W-1], sd_c[DIFF_W-1]};
        end
    end

    rmq_div #(.DW(DW), .PW(PW)) u_div_a (
        .clk(clk), .en(en), .dividend(dvd_a_reg), .divisor(p_reg), .quotient(quo_a)
    );

    rmq_div #(.DW(DW), .PW(PW)) u_div_b (
        .clk(clk), .en(en), .dividend(dvd_b_reg), .divisor(p_reg), .quotient(quo_b)
    );

    rmq_div #(.DW(DW), .PW(PW)) u_div_c (
        .clk(clk), .en(en), .dividend(dvd_c_reg), .divisor(p_reg), .quotient(quo_c)
    );

    for (genvar s = 0; s < DW; s++)
    begin : g_dl
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dl_reg[s] <= (s == 0) ? prep_side_reg : dl_reg[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dl_vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                dl_vld_reg[s] <= (s == 0) ? prep_vld_reg : dl_vld_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    always_comb
    begin
        f_ctl = rmq_ctl_t'(dl_reg[DW-1][DL_W-1 -: CTL_W]);
        f_p = dl_reg[DW-1][PW+2:3];
        f_neg_a = dl_reg[DW-1][2];
        f_neg_b = dl_reg[DW-1][1];
        f_neg_c = dl_reg[DW-1][0];
        for (int c = 0; c < 4; c++)
        begin
            res[c] = '0;
        end
        if (!f_ctl.degen)
        begin
            res[f_ctl.pslot] = sat_mag(DW'(f_p), 1'b0);
            res[f_ctl.slot_a] = sat_mag(quo_a, f_neg_a);
            res[f_ctl.slot_b] = sat_mag(quo_b, f_neg_b);
            res[f_ctl.slot_c] = sat_mag(quo_c, f_neg_c);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg <= res[COMP_X];
            qy_reg <= res[COMP_Y];
            qz_reg <= res[COMP_Z];
            qw_reg <= res[COMP_W];
            degen_reg <= f_ctl.degen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_vld_reg <= sq_valid;
            out_valid_reg <= dl_vld_reg[DW-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign quat_x = $signed(qx_reg);
    assign quat_y = $signed(qy_reg);
    assign quat_z = $signed(qz_reg);
    assign quat_w = $signed(qw_reg);
    assign degenerate = degen_reg;

endmodule

// File: rtl/rmq_checker.sv
// port-level checks for the matrix to quaternion block and their binding
`timescale 1ns / 1ps

module rmq_checker import rmq_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic signed [IN_W-1:0] quat_x,
    input logic signed [IN_W-1:0] quat_y,
    input logic signed [IN_W-1:0] quat_z,
    input logic signed [IN_W-1:0] quat_w,
    input logic                   degenerate
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(quat_x) && $stable(quat_y) && $stable(quat_z)
            && $stable(quat_w) && $stable(degenerate))
        else $error("stalled result changed");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> quat_x == 0 && quat_y == 0 && quat_z == 0 && quat_w == 0)
        else $error("degenerate item with nonzero components");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .quat_x(quat_x),
    .quat_y(quat_y),
    .quat_z(quat_z),
    .quat_w(quat_w),
    .degenerate(degenerate)
);

// File: tb/sv/rotation_matrix_to_quaternion_tb.sv
// testbench for the rotation matrix to quaternion converter: directed table, random items, predictor check
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;
    import rmq_pkg::*;

    localparam int FRAC = 14;
    localparam int LATENCY = 49;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1200;

    typedef logic signed [IN_W-1:0] elem_t;
    typedef elem_t mat_t [9];

    typedef struct packed {
        elem_t qx;
        elem_t qy;
        elem_t qz;
        elem_t qw;
        logic  degen;
    } quat_t;

    typedef struct {
        mat_t  m;
        logic  known;
        quat_t q;
    } row_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    elem_t mi [9];
    logic  out_valid;
    logic  out_stall = 1'b0;
    elem_t quat_x, quat_y, quat_z, quat_w;
    logic  degenerate;

    quat_t pending_quats [$];
    int    n_fail = 0;
    int    idle_cycles = 0;
    logic  send_done = 1'b0;
    logic  long_hold = 1'b0;

    initial
    begin
        for (int i = 0; i < 9; i++)
        begin
            mi[i] = '0;
        end
    end

    always #5 clk = ~clk;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .m00(mi[0]), .m01(mi[1]), .m02(mi[2]), .m10(mi[3]), .m11(mi[4]),
        .m12(mi[5]), .m20(mi[6]), .m21(mi[7]), .m22(mi[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .degenerate(degenerate)
    );

    function automatic longint root64(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
        begin
            b >>= 2;
        end
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint round_div(longint d, longint p);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        q = ((mag << (FRAC - 2)) + (p >> 1)) / p;
        return (d < 0) ? -q : q;
    endfunction

    function automatic elem_t clamp16(longint v);
        if (v > 32767)
        begin
            return 16'sh7fff;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return elem_t'(v);
    endfunction

    function automatic quat_t quat_of_matrix(mat_t mm);
        longint e [3][3];
        longint q [4];
        longint tr, rad, p;
        int     a, b, c;
        int     nxt [3];
        quat_t  res;
        nxt = '{1, 2, 0};
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e[r][k] = longint'(mm[r * 3 + k]);
            end
        end
        res.degen = 1'b0;
        tr = e[0][0] + e[1][1] + e[2][2];
        if (tr > 0)
        begin
            rad = tr + (64'sd1 <<< FRAC);
            p = root64(longint'(rad) << (FRAC - 2));
            q[3] = p;
            q[0] = round_div(e[1][2] - e[2][1], p);
            q[1] = round_div(e[2][0] - e[0][2], p);
            q[2] = round_div(e[0][1] - e[1][0], p);
        end
        else
        begin
            a = 0;
            if (e[1][1] > e[0][0])
            begin
                a = 1;
            end
            if (e[2][2] > e[a][a])
            begin
                a = 2;
            end
            b = nxt[a];
            c = nxt[b];
            rad = e[a][a] - e[b][b] - e[c][c] + (64'sd1 <<< FRAC);
            if (rad <= 0)
            begin
                res.qx = '0;
                res.qy = '0;
                res.qz = '0;
                res.qw = '0;
                res.degen = 1'b1;
                return res;
            end
            p = root64(longint'(rad) << (FRAC - 2));
            q[a] = p;
            q[3] = round_div(e[b][c] - e[c][b], p);
            q[b] = round_div(e[a][b] + e[b][a], p);
            q[c] = round_div(e[a][c] + e[c][a], p);
        end
        res.qx = clamp16(q[0]);
        res.qy = clamp16(q[1]);
        res.qz = clamp16(q[2]);
        res.qw = clamp16(q[3]);
        return res;
    endfunction

    function automatic row_t mk(elem_t a0, elem_t a1, elem_t a2, elem_t a3, elem_t a4,
                                elem_t a5, elem_t a6, elem_t a7, elem_t a8,
                                logic kn, elem_t x, elem_t y, elem_t z, elem_t w, logic dg);
        row_t r;
        r.m = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
        r.known = kn;
        r.q = '{x, y, z, w, dg};
        return r;
    endfunction

    function automatic mat_t random_matrix();
        mat_t mm;
        int   mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
        begin
            case (mode)
                0, 1, 2: mm[i] = elem_t'($urandom);
                3:       mm[i] = elem_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
                default: mm[i] = elem_t'($signed($urandom_range(0, 32768)) - 16384);
            endcase
        end
        if (mode == 9)
        begin
            mm[0] = elem_t'(-$signed($urandom_range(0, 16384)));
            mm[4] = mm[0];
            mm[8] = elem_t'(-$signed($urandom_range(0, 16384)));
        end
        return mm;
    endfunction

    task automatic send_matrix(mat_t mm, logic kn, quat_t want);
        int gap;
        gap = long_hold ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < 9; i++)
        begin
            mi[i] <= mm[i];
        end
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (kn && quat_of_matrix(mm) != want)
        begin
            $error("directed row disagrees with predictor");
            n_fail++;
        end
        pending_quats.push_back(quat_of_matrix(mm));
    endtask

    row_t dir_rows [$];

    initial
    begin
        mat_t mm;
        quat_t none;
        none = '{0, 0, 0, 0, 0};
        // identity, half-turns about each axis, ties, extremes
        dir_rows.push_back(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1, 0, 0, 0, 16384, 0));
        dir_rows.push_back(mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384, 1, 16384, 0, 0, 0, 0));
        dir_rows.push_back(mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384, 1, 0, 16384, 0, 0, 0));
        dir_rows.push_back(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384, 1, 0, 0, 16384, 0, 0));
        dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8192, 0, 0, 0, 0));
        dir_rows.push_back(mk(-32768, 0, 0, 0, 32767, 0, 0, 0, 32767, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                              -32768, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                              0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0,
                              0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(-5, 100, 200, 300, -5, 400, 500, 600, -5, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(-100, 7, -7, 9, -100, -9, 11, -11, -200, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(-200, 32767, 32767, 32767, -100, 32767, 32767, 32767, -200,
                              0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(-32768, 0, 0, 0, -32768, 0, 0, 0, 16383, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384, 0, 0, 0, 0, 0, 1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
        begin
            send_matrix(dir_rows[i].m, dir_rows[i].known, dir_rows[i].q);
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 300)
            begin
                long_hold <= 1'b1;
            end
            if (n == 340)
            begin
                long_hold <= 1'b0;
            end
            if (n == 700)
            begin
                in_valid <= 1'b0;
                while (pending_quats.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            mm = random_matrix();
            send_matrix(mm, 1'b0, none);
        end
        in_valid <= 1'b0;
        send_done <= 1'b1;
    end

    // output side: random stalls, one long hold-off while the sender keeps going
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                out_stall <= 1'b0;
                wait (!long_hold);
            end
            w = $urandom_range(0, 14);
            if ($urandom_range(0, 2) == 0 || w == 0)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        quat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_quats.size() == 0)
            begin
                $error("result item with nothing expected");
                n_fail++;
            end
            else
            begin
                want = pending_quats.pop_front();
                if (quat_x !== want.qx)
                begin
                    $error("quat_x expected %0d actual %0d", want.qx, quat_x);
                    n_fail++;
                end
                if (quat_y !== want.qy)
                begin
                    $error("quat_y expected %0d actual %0d", want.qy, quat_y);
                    n_fail++;
                end
                if (quat_z !== want.qz)
                begin
                    $error("quat_z expected %0d actual %0d", want.qz, quat_z);
                    n_fail++;
                end
                if (quat_w !== want.qw)
                begin
                    $error("quat_w expected %0d actual %0d", want.qw, quat_w);
                    n_fail++;
                end
                if (degenerate !== want.degen)
                begin
                    $error("degenerate expected %0d actual %0d", want.degen, degenerate);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        @(posedge rst_n);
        fork
            begin
                wait (send_done && pending_quats.size() == 0);
                repeat (LATENCY + 10) @(posedge clk);
            end
            begin
                wait (idle_cycles >= WATCHDOG);
                n_fail++;
            end
        join_any
        if (n_fail == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
